### src/pfra_pkg.sv
// Shared types and constants of the phase fit residual accumulator.
package pfra_pkg;

   // Field and datapath widths.
   localparam int BASIS_W     = 16;
   localparam int MEAS_W      = 16;
   localparam int COEF_W      = 32;
   localparam int STEP_W      = 16;
   localparam int MULT_W      = BASIS_W + COEF_W;
   localparam int PHASE_W     = 30;
   localparam int ANGLE_W     = 16;
   localparam int TAB_W       = 15;
   localparam int COS_W       = 16;
   localparam int ERR_W       = 17;
   localparam int SQ_W        = 32;
   localparam int PAIR_W      = SQ_W + 1;
   localparam int SUM_W       = 48;
   localparam int NUM_COEF    = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index of the frame phase step; indexes below it select a coefficient.
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = CSR_INDEX_W'(NUM_COEF);

   // Fixed point constants for building the cosine table (Q30).
   localparam longint Q30_ONE     = 64'sd1 <<< 30;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // One pixel transaction.
   typedef struct packed {
      logic signed [BASIS_W-1:0] basis_0;
      logic signed [BASIS_W-1:0] basis_1;
      logic signed [BASIS_W-1:0] basis_2;
      logic signed [BASIS_W-1:0] basis_3;
      logic signed [BASIS_W-1:0] basis_4;
      logic signed [BASIS_W-1:0] basis_5;
      logic signed [BASIS_W-1:0] basis_6;
      logic signed [MEAS_W-1:0]  meas_first;
      logic signed [MEAS_W-1:0]  meas_second;
      logic                      last_pixel;
   } req_payload_type;

   // One frame result transaction.
   typedef struct packed {
      logic [SUM_W-1:0] fitness;
      logic             saturated;
   } rsp_payload_type;

   // Per pixel side data that travels along the pipeline.
   typedef struct packed {
      logic signed [MEAS_W-1:0] meas_first;
      logic signed [MEAS_W-1:0] meas_second;
      logic                     last_pixel;
   } pipe_ctrl_type;

endpackage

### src/phase_fit_residual_accumulator.sv
// Top level of the phase fit residual accumulator.
//
// Scores one phase-fit candidate over a frame of pixels. Each pixel transaction enters an
// eight stage pipeline: one multiplier lane per basis term, a merge stage that sums the lane
// products into a binary angle, two cosine units (first frame and shifted frame) each with
// its own quarter-wave table, residual, square, pair sum, and a saturating 48-bit
// accumulator. One pixel is taken every cycle while req_stall is low, and the frame result
// is registered as the last pixel is accumulated. The pipeline halts, and req_stall rises,
// only while a last pixel reaches the accumulator and the previous frame result is still
// held by rsp_stall. The cosine tables are constant, so there is no start-up pass after
// reset. Coefficients and the phase step are written through the csr port; the user must
// write them only while no pixels are in flight, as the block does not enforce it.
module phase_fit_residual_accumulator #(
   parameter int TERMS           = 7,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Pixel channel.
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pfra_pkg::req_payload_type             req_payload,
   // Frame result channel.
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pfra_pkg::rsp_payload_type             rsp_payload,
   // Register write port.
   input  logic                                  csr_we,
   input  logic [pfra_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pfra_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int TERMS_EFF = (TERMS > pfra_pkg::NUM_COEF) ? pfra_pkg::NUM_COEF :
                              ((TERMS < 1) ? 1 : TERMS);
   localparam int DEPTH_EFF = (COS_TABLE_DEPTH > 4096) ? 4096 :
                              ((COS_TABLE_DEPTH < 64) ? 64 : COS_TABLE_DEPTH);
   localparam int STAGES    = 8;

   localparam logic [pfra_pkg::SUM_W-1:0] SUM_MAX = '1;

   // Configuration registers.
   logic signed [pfra_pkg::COEF_W-1:0] coef_ff [pfra_pkg::NUM_COEF];
   logic        [pfra_pkg::STEP_W-1:0] phase_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < pfra_pkg::NUM_COEF; j++) begin
            coef_ff[j] <= '0;
         end
         phase_step_ff <= '0;
      end else if (csr_we) begin
         for (int j = 0; j < pfra_pkg::NUM_COEF; j++) begin
            if (csr_index == pfra_pkg::CSR_INDEX_W'(j)) begin
               coef_ff[j] <= $signed(csr_wdata);
            end
         end
         if (csr_index == pfra_pkg::CSR_PHASE_STEP) begin
            phase_step_ff <= csr_wdata[pfra_pkg::STEP_W-1:0];
         end
      end
   end

   // Pipeline advance: only a last pixel blocked by a held frame result halts it.
   logic [STAGES:1]          valid_ff;
   pfra_pkg::pipe_ctrl_type  ctrl_ff [STAGES:1];
   logic                     rsp_valid_ff;
   logic                     out_free;
   logic                     advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = !(valid_ff[STAGES] && ctrl_ff[STAGES].last_pixel && !out_free);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[STAGES-1:1], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctrl_ff[1].meas_first  <= req_payload.meas_first;
         ctrl_ff[1].meas_second <= req_payload.meas_second;
         ctrl_ff[1].last_pixel  <= req_payload.last_pixel;
         for (int k = 2; k <= STAGES; k++) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
         end
      end
   end

   // Basis values as an array for the lanes.
   logic signed [pfra_pkg::BASIS_W-1:0] basis_arr [pfra_pkg::NUM_COEF];

   assign basis_arr[0] = req_payload.basis_0;
   assign basis_arr[1] = req_payload.basis_1;
   assign basis_arr[2] = req_payload.basis_2;
   assign basis_arr[3] = req_payload.basis_3;
   assign basis_arr[4] = req_payload.basis_4;
   assign basis_arr[5] = req_payload.basis_5;
   assign basis_arr[6] = req_payload.basis_6;

   // Stage 1: one multiplier lane per used basis term.
   logic [pfra_pkg::PHASE_W-1:0] lane_prod [TERMS_EFF];

   for (genvar j = 0; j < TERMS_EFF; j++) begin : g_lane
      pfra_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .basis  (basis_arr[j]),
         .coef   (coef_ff[j]),
         .prod   (lane_prod[j])
      );
   end

   // Stage 2: merge lanes into the first frame angle.
   logic [pfra_pkg::ANGLE_W-1:0] angle_first;
   logic [pfra_pkg::ANGLE_W-1:0] angle_second;

   pfra_merge #(
      .TERMS (TERMS_EFF)
   ) u_merge (
      .clock  (clock),
      .enable (advance),
      .prod   (lane_prod),
      .angle  (angle_first)
   );

   assign angle_second = angle_first + phase_step_ff;

   // Stages 3 to 5: cosine of both angles.
   logic signed [pfra_pkg::COS_W-1:0] cos_first;
   logic signed [pfra_pkg::COS_W-1:0] cos_second;

   pfra_cos #(
      .DEPTH (DEPTH_EFF)
   ) u_cos_first (
      .clock     (clock),
      .enable    (advance),
      .angle     (angle_first),
      .cos_value (cos_first)
   );

   pfra_cos #(
      .DEPTH (DEPTH_EFF)
   ) u_cos_second (
      .clock     (clock),
      .enable    (advance),
      .angle     (angle_second),
      .cos_value (cos_second)
   );

   // Stage 6: residuals against the measured intensities.
   logic signed [pfra_pkg::ERR_W-1:0] err_first_ff;
   logic signed [pfra_pkg::ERR_W-1:0] err_second_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         err_first_ff  <= pfra_pkg::ERR_W'(cos_first) - pfra_pkg::ERR_W'(ctrl_ff[5].meas_first);
         err_second_ff <= pfra_pkg::ERR_W'(cos_second) - pfra_pkg::ERR_W'(ctrl_ff[5].meas_second);
      end
   end

   // Stage 7: squared residuals.
   logic signed [2*pfra_pkg::ERR_W-1:0] sq_first;
   logic signed [2*pfra_pkg::ERR_W-1:0] sq_second;
   logic        [pfra_pkg::SQ_W-1:0]    sq_first_ff;
   logic        [pfra_pkg::SQ_W-1:0]    sq_second_ff;

   assign sq_first  = err_first_ff * err_first_ff;
   assign sq_second = err_second_ff * err_second_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_first_ff  <= sq_first[pfra_pkg::SQ_W-1:0];
         sq_second_ff <= sq_second[pfra_pkg::SQ_W-1:0];
      end
   end

   // Stage 8: both frames' contribution of this pixel.
   logic [pfra_pkg::PAIR_W-1:0] pair_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pfra_pkg::PAIR_W'(sq_first_ff) + pfra_pkg::PAIR_W'(sq_second_ff);
      end
   end

   // Saturating accumulator and frame result register.
   logic [pfra_pkg::SUM_W-1:0]   sum_ff;
   logic                         clip_ff;
   logic [pfra_pkg::SUM_W:0]     total;
   logic                         overflow;
   logic [pfra_pkg::SUM_W-1:0]   sum_in;
   logic                         clip_in;
   logic                         take;
   pfra_pkg::rsp_payload_type    rsp_payload_ff;

   assign take     = advance && valid_ff[STAGES];
   assign total    = {1'b0, sum_ff} + (pfra_pkg::SUM_W + 1)'(pair_ff);
   assign overflow = total[pfra_pkg::SUM_W];
   assign sum_in   = overflow ? SUM_MAX : total[pfra_pkg::SUM_W-1:0];
   assign clip_in  = clip_ff || overflow;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         clip_ff <= 1'b0;
      end else if (take) begin
         if (ctrl_ff[STAGES].last_pixel) begin
            sum_ff  <= '0;
            clip_ff <= 1'b0;
         end else begin
            sum_ff  <= sum_in;
            clip_ff <= clip_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && ctrl_ff[STAGES].last_pixel) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take && ctrl_ff[STAGES].last_pixel) begin
         rsp_payload_ff.fitness   <= sum_in;
         rsp_payload_ff.saturated <= clip_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### src/pfra_lane.sv
// One phase lane: basis value times coefficient, reduced to one turn and registered.
module pfra_lane (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [pfra_pkg::BASIS_W-1:0]   basis,
   input  logic signed [pfra_pkg::COEF_W-1:0]    coef,
   output logic        [pfra_pkg::PHASE_W-1:0]   prod
);

   logic signed [pfra_pkg::MULT_W-1:0] full_prod;
   logic        [pfra_pkg::PHASE_W-1:0] prod_ff;

   // Full signed product; only the bits below one turn are kept.
   assign full_prod = pfra_pkg::MULT_W'(basis) * pfra_pkg::MULT_W'(coef);

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= full_prod[pfra_pkg::PHASE_W-1:0];
      end
   end

   assign prod = prod_ff;

endmodule

### src/pfra_merge.sv
// Merge stage: adds the lane products modulo one turn and yields the binary angle.
module pfra_merge #(
   parameter int TERMS = 7
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [pfra_pkg::PHASE_W-1:0]        prod [TERMS],
   output logic [pfra_pkg::ANGLE_W-1:0]        angle
);

   logic [pfra_pkg::PHASE_W-1:0] sum_in;
   logic [pfra_pkg::PHASE_W-1:0] sum_ff;

   // The sum wraps naturally at one turn.
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < TERMS; j++) begin
         sum_in = sum_in + prod[j];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

   // The angle is the top bits of the turn, found by truncation.
   assign angle = sum_ff[pfra_pkg::PHASE_W-1 -: pfra_pkg::ANGLE_W];

endmodule

### src/pfra_cos.sv
// Cosine unit: quadrant decode and quarter-wave table lookup, three register stages.
module pfra_cos #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [pfra_pkg::ANGLE_W-1:0]        angle,
   output logic signed [pfra_pkg::COS_W-1:0]   cos_value
);

   localparam int SCALE = 4 * DEPTH;
   localparam int MW    = pfra_pkg::ANGLE_W + $clog2(SCALE + 1);
   localparam int PW    = $clog2(SCALE);
   localparam int AW    = $clog2(DEPTH + 1);

   localparam logic [PW-1:0] Q1_START = PW'(DEPTH);
   localparam logic [PW-1:0] Q2_START = PW'(2 * DEPTH);
   localparam logic [PW-1:0] Q3_START = PW'(3 * DEPTH);

   logic [pfra_pkg::TAB_W-1:0] rom_table [DEPTH + 1];

   // Quarter-wave table T[k] = cos(k*pi/(2*DEPTH)) in unsigned Q0.15, from a Q30 Taylor series.
   for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
      localparam longint X  = (pfra_pkg::HALF_PI_Q30 * k) / DEPTH;
      localparam longint X2 = (X * X) >>> 30;
      localparam longint T0 = pfra_pkg::Q30_ONE;
      localparam longint T1 = -(T0 * X2) / (2 * 1 * pfra_pkg::Q30_ONE);
      localparam longint T2 = -(T1 * X2) / (4 * 3 * pfra_pkg::Q30_ONE);
      localparam longint T3 = -(T2 * X2) / (6 * 5 * pfra_pkg::Q30_ONE);
      localparam longint T4 = -(T3 * X2) / (8 * 7 * pfra_pkg::Q30_ONE);
      localparam longint T5 = -(T4 * X2) / (10 * 9 * pfra_pkg::Q30_ONE);
      localparam longint T6 = -(T5 * X2) / (12 * 11 * pfra_pkg::Q30_ONE);
      localparam longint T7 = -(T6 * X2) / (14 * 13 * pfra_pkg::Q30_ONE);
      localparam longint S  = T0 + T1 + T2 + T3 + T4 + T5 + T6 + T7;
      localparam longint R  = (S < 0) ? 64'sd0 : ((S + (64'sd1 <<< 14)) >>> 15);
      localparam longint V  = (R > 64'sd32767) ? 64'sd32767 : R;
      assign rom_table[k] = pfra_pkg::TAB_W'(V);
   end

   logic [MW-1:0]               scaled;
   logic [PW-1:0]               pos_ff;
   logic [1:0]                  quad;
   logic [PW-1:0]               offset;
   logic [AW-1:0]               idx_in;
   logic [AW-1:0]               idx_ff;
   logic                        neg_idx_ff;
   logic [pfra_pkg::TAB_W-1:0]  data_ff;
   logic                        neg_data_ff;

   // Stage A: position along the full wave in table steps.
   assign scaled = MW'(angle) * MW'(SCALE);

   always_ff @(posedge clock) begin
      if (enable) begin
         pos_ff <= scaled[pfra_pkg::ANGLE_W +: PW];
      end
   end

   // Stage B: quadrant and offset; odd quadrants read the table mirrored.
   always_comb begin
      if (pos_ff >= Q3_START) begin
         quad   = 2'd3;
         offset = pos_ff - Q3_START;
      end else if (pos_ff >= Q2_START) begin
         quad   = 2'd2;
         offset = pos_ff - Q2_START;
      end else if (pos_ff >= Q1_START) begin
         quad   = 2'd1;
         offset = pos_ff - Q1_START;
      end else begin
         quad   = 2'd0;
         offset = pos_ff;
      end
      idx_in = quad[0] ? (AW'(DEPTH) - AW'(offset)) : AW'(offset);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         idx_ff     <= idx_in;
         neg_idx_ff <= quad[0] ^ quad[1];
      end
   end

   // Stage C: registered table read.
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff     <= rom_table[idx_ff];
         neg_data_ff <= neg_idx_ff;
      end
   end

   // Second and third quadrants carry a negative cosine.
   assign cos_value = neg_data_ff ? -$signed({1'b0, data_ff}) : $signed({1'b0, data_ff});

endmodule
